// ===== hdl/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text-mode console writer: the command
// and response transfer formats, operation codes and character codes.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	// Operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_SET   = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Control and printable character codes
	localparam logic [7:0] CH_BS       = 8'd8;
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] CH_PRINT_LO = 8'd32;
	localparam logic [7:0] CH_PRINT_HI = 8'd126;

	// Spaces written for one tab
	localparam int unsigned TAB_SPACES = 4;

	// Attribute after reset and the blank cell the screen holds after reset
	localparam logic [7:0]  ATTR_RESET = 8'h07;
	localparam logic [15:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

	// Configuration register index (byte address bit 2)
	localparam logic REG_ATTR = 1'b0;

	// Command transfer
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
		logic [6:0] target_col;
		logic [4:0] target_row;
	} cmd_t;

	// Response transfer
	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_offset;
		logic [15:0] cell_value;
	} rsp_t;

endpackage

// ===== hdl/tmcw_ram.sv =====
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual-port RAM: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/tmcw_cfg.sv =====
// ----------------------------------------------------------------------------
// tmcw_cfg
// APB-style register port holding the text attribute used for writes,
// blanks and clears.
// ----------------------------------------------------------------------------
module tmcw_cfg import tmcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  attr
);

	logic [7:0] attr_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign attr   = attr_q;

	// Write the attribute register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (wr_en && paddr[2] == REG_ATTR) begin
			attr_q <= pwdata[7:0];
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			REG_ATTR: prdata = {24'd0, attr_q};
			default:  prdata = '0;
		endcase
	end

endmodule

// ===== hdl/tmcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Command sequencer: holds the cursor and walks the screen memory for
// character writes, scrolls, clears, reads and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tmcw_ctrl import tmcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] attr,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	input  logic       room,
	output logic       res_valid,
	output rsp_t       res
);

	localparam int CW     = $clog2(COLUMNS);
	localparam int RW     = $clog2(ROWS);
	localparam int AW     = RW + CW;
	localparam int DEPTH  = ROWS << CW;

	typedef enum logic [7:0] {
		ST_FILL   = 8'b00000001,
		ST_IDLE   = 8'b00000010,
		ST_PUT    = 8'b00000100,
		ST_SCROLL = 8'b00001000,
		ST_DRAIN  = 8'b00010000,
		ST_BLANK  = 8'b00100000,
		ST_RDWAIT = 8'b01000000,
		ST_DONE   = 8'b10000000
	} state_t;

	state_t         state_q;
	logic           init_q;
	logic [15:0]    fill_q;
	logic [RW-1:0]  r_q;
	logic [CW-1:0]  c_q;
	logic [6:0]     col_q;
	logic [4:0]     row_q;
	logic [7:0]     ch_q;
	logic [1:0]     tab_q;
	logic           pend_q;
	logic [15:0]    cell_q;
	logic           cp_s1;
	logic [AW-1:0]  cp_addr_s1;

	logic           we;
	logic [AW-1:0]  waddr;
	logic [15:0]    wdata;
	logic [AW-1:0]  raddr;
	logic [15:0]    rdata;
	logic [AW-1:0]  cur_addr;
	logic           c_last;
	logic           r_last;
	logic           col_last;
	logic           row_last;
	logic           tgt_ok;
	logic           printable;
	logic [12:0]    off_full;

	assign cur_addr  = {row_q[RW-1:0], col_q[CW-1:0]};
	assign c_last    = (c_q == CW'(COLUMNS - 1));
	assign r_last    = (r_q == RW'(ROWS - 1));
	assign col_last  = (col_q == 7'(COLUMNS - 1));
	assign row_last  = (row_q == 5'(ROWS - 1));
	assign tgt_ok    = ({1'b0, cmd.target_col} < 8'(COLUMNS)) &&
	                   ({1'b0, cmd.target_row} < 6'(ROWS));
	assign printable = (cmd.char_code >= CH_PRINT_LO) && (cmd.char_code <= CH_PRINT_HI);

	// Screen memory
	tmcw_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Memory port selection per state
	always_comb begin
		we    = 1'b0;
		waddr = cur_addr;
		wdata = {attr, CH_SPACE};
		raddr = {cmd.target_row[RW-1:0], cmd.target_col[CW-1:0]};
		unique case (state_q)
			ST_FILL: begin
				we    = 1'b1;
				waddr = {r_q, c_q};
				wdata = fill_q;
			end
			ST_IDLE: begin
				// backspace blanks the cell left of the cursor
				if (cmd_valid && cmd.op == OP_PUT && cmd.char_code == CH_BS &&
				    col_q != '0) begin
					we    = 1'b1;
					waddr = {row_q[RW-1:0], CW'(col_q - 7'd1)};
				end
			end
			ST_PUT: begin
				we    = 1'b1;
				wdata = {attr, ch_q};
			end
			ST_SCROLL, ST_DRAIN: begin
				raddr = {RW'(r_q + 1'b1), c_q};
				we    = cp_s1;
				waddr = cp_addr_s1;
				wdata = rdata;
			end
			ST_BLANK: begin
				we    = 1'b1;
				waddr = {RW'(ROWS - 1), c_q};
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			init_q     <= 1'b1;
			fill_q     <= CELL_RESET;
			r_q        <= '0;
			c_q        <= '0;
			col_q      <= '0;
			row_q      <= '0;
			ch_q       <= '0;
			tab_q      <= '0;
			pend_q     <= 1'b0;
			cell_q     <= '0;
			cp_s1      <= 1'b0;
			cp_addr_s1 <= '0;
		end else begin
			// copy pipeline: data read in this cycle is written to the row above next cycle
			cp_s1      <= (state_q == ST_SCROLL);
			cp_addr_s1 <= {r_q, c_q};
			unique case (state_q)
				ST_FILL: begin
					c_q <= c_last ? '0 : c_q + 1'b1;
					if (c_last) begin
						r_q <= r_last ? '0 : r_q + 1'b1;
						if (r_last) begin
							state_q <= init_q ? ST_IDLE : ST_DONE;
							init_q  <= 1'b0;
						end
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cell_q <= '0;
						unique case (cmd.op)
							OP_PUT: begin
								case (cmd.char_code)
									CH_CR: begin
										col_q   <= '0;
										state_q <= ST_DONE;
									end
									CH_LF: begin
										col_q  <= '0;
										pend_q <= 1'b0;
										if (row_last) begin
											r_q     <= '0;
											c_q     <= '0;
											state_q <= ST_SCROLL;
										end else begin
											row_q   <= row_q + 1'b1;
											state_q <= ST_DONE;
										end
									end
									CH_TAB: begin
										ch_q    <= CH_SPACE;
										tab_q   <= 2'(TAB_SPACES - 1);
										state_q <= ST_PUT;
									end
									CH_BS: begin
										if (col_q != '0) begin
											col_q <= col_q - 1'b1;
										end
										state_q <= ST_DONE;
									end
									default: begin
										ch_q    <= cmd.char_code;
										tab_q   <= '0;
										state_q <= printable ? ST_PUT : ST_DONE;
									end
								endcase
							end
							OP_CLEAR: begin
								fill_q  <= {attr, CH_SPACE};
								r_q     <= '0;
								c_q     <= '0;
								col_q   <= '0;
								row_q   <= '0;
								state_q <= ST_FILL;
							end
							OP_SET: begin
								if (tgt_ok) begin
									col_q <= cmd.target_col;
									row_q <= cmd.target_row;
								end
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= tgt_ok ? ST_RDWAIT : ST_DONE;
							end
						endcase
					end
				end
				ST_PUT: begin
					// one character cell, then wrap and maybe scroll
					pend_q <= (tab_q != '0);
					if (tab_q != '0) begin
						tab_q <= tab_q - 1'b1;
					end
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							r_q     <= '0;
							c_q     <= '0;
							state_q <= ST_SCROLL;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= (tab_q != '0) ? ST_PUT : ST_DONE;
						end
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= (tab_q != '0) ? ST_PUT : ST_DONE;
					end
				end
				ST_SCROLL: begin
					c_q <= c_last ? '0 : c_q + 1'b1;
					if (c_last) begin
						r_q <= r_q + 1'b1;
						if (r_q == RW'(ROWS - 2)) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					c_q     <= '0;
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					c_q <= c_last ? '0 : c_q + 1'b1;
					if (c_last) begin
						state_q <= pend_q ? ST_PUT : ST_DONE;
					end
				end
				ST_RDWAIT: begin
					cell_q  <= rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (room) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result
	assign off_full          = 13'(row_q) * 13'(COLUMNS) + 13'(col_q);
	assign cmd_ready         = (state_q == ST_IDLE);
	assign res_valid         = (state_q == ST_DONE) && room;
	assign res.cursor_col    = col_q;
	assign res.cursor_row    = row_q;
	assign res.cursor_offset = off_full[10:0];
	assign res.cell_value    = cell_q;

endmodule

// ===== hdl/text_mode_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Text-mode console engine: character screen in a memory, cursor, scroll,
// clear, cursor set and cell read.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on cmd (valid/ready), one response per command leaves on
//   rsp (valid/ready) reporting the cursor, its offset and, for a cell read,
//   the cell. The attribute register is written through the APB-style port.
//   Commands are taken one at a time; cmd_ready is high only when idle.
//   A scroll and a clear are both bound by the single write port of the screen
//   memory, one cell per cycle. After reset the screen memory is swept to
//   blank cells with cmd_ready low; the attribute register can be written
//   meanwhile.
//   A response waits in the output register while rsp_ready is low; the next
//   command is still accepted and completes into the sequencer, which holds
//   its response until the output register frees.
// ----------------------------------------------------------------------------
module text_mode_console_writer import tmcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp
);

	logic [7:0] attr;
	logic       room;
	logic       res_valid;
	rsp_t       res;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	tmcw_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.attr   (attr)
	);

	tmcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.attr     (attr),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.room     (room),
		.res_valid(res_valid),
		.res      (res)
	);

	// Output register: load a finished response when the slot is free
	assign room = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (room) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hdl/tmcw_checker.sv =====
// ----------------------------------------------------------------------------
// tmcw_checker
// Port-level checks of the text-mode console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tmcw_checker import tmcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp,
	input logic pready
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Drop ready after a command transfer: one command in work at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while another is in work");

	// Cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, rsp.cursor_col} < 8'(COLUMNS)) &&
		              ({1'b0, rsp.cursor_row} < 6'(ROWS)))
		else $error("cursor off screen");

	// Offset agrees with row and column
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.cursor_offset ==
		              11'(13'(rsp.cursor_row) * 13'(COLUMNS) + 13'(rsp.cursor_col)))
		else $error("cursor offset mismatch");

	// Register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("register port stalled");

endmodule

bind text_mode_console_writer tmcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tmcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp),
	.pready   (pready)
);
